// ----- design/drlc_pkg.sv -----
// ----------------------------------------------------------------------------
// drlc_pkg
// Shared types and constants of the delimited record line checker.
// ----------------------------------------------------------------------------
package drlc_pkg;

   // counter and field count widths
   localparam int COUNT_BITS = 24;
   localparam int FIELD_BITS = 8;

   // port widths fixed by the interface
   localparam int OUT_BITS   = 24;
   localparam int REQ_BITS   = 8;
   localparam int CSR_IDX_BITS  = 8;
   localparam int CSR_DATA_BITS = 8;

   // wide enough to compare a field count against the required count
   localparam int CMP_BITS = (FIELD_BITS > REQ_BITS) ? FIELD_BITS : REQ_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_REQUIRED_FIELDS = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] REG_SKIP_BLANK      = CSR_IDX_BITS'(1);

   // input item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // characters of interest
   localparam logic [7:0] CHAR_PIPE = 8'h7C;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_SP   = 8'h20;
   localparam logic [7:0] CHAR_TAB  = 8'h09;
   localparam logic [7:0] CHAR_VT   = 8'h0B;
   localparam logic [7:0] CHAR_FF   = 8'h0C;

   // line status codes
   typedef enum logic [1:0] {
      STATUS_VALID    = 2'd0,
      STATUS_SKIPPED  = 2'd1,
      STATUS_MISMATCH = 2'd2,
      STATUS_EMPTY    = 2'd3
   } line_status_type;

   // first invalid reason codes
   typedef enum logic [1:0] {
      REASON_NONE     = 2'd0,
      REASON_MISMATCH = 2'd1,
      REASON_EMPTY    = 2'd2
   } reason_type;

endpackage

// ----- design/delimited_record_line_checker.sv -----
// ----------------------------------------------------------------------------
// delimited_record_line_checker
// Checks pipe separated records, one text byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one byte (or an end-of-text marker) per cycle and answers
// each closed line with one registered result in the cycle after the closing transfer; CR,
// LF and CR LF end a line, an LF right after a CR gives no result. All work is
// a few flags and saturating counters updated in the accepting cycle, so a new
// transfer is taken every cycle as long as the result register is empty or is
// being emptied in the same cycle. End of text closes the final line and then
// restarts all counters; the two configuration registers keep their values and
// should only be written while no result is pending.
module delimited_record_line_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   // input channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic [drlc_pkg::REQ_BITS-1:0]         req_char_code,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [drlc_pkg::OUT_BITS-1:0]         rsp_line_number,
   output logic [1:0]                            rsp_line_status,
   output logic [drlc_pkg::OUT_BITS-1:0]         rsp_invalid_count,
   output logic [drlc_pkg::OUT_BITS-1:0]         rsp_first_invalid_line,
   output logic [1:0]                            rsp_first_reason,
   output logic                                  rsp_all_ok,
   output logic                                  rsp_done_res,
   // configuration port
   input  logic                                  csr_write_enable,
   input  logic [drlc_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [drlc_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import drlc_pkg::*;

   // configuration
   logic [REQ_BITS-1:0]   required_ff;
   logic                  skip_blank_ff;

   // line and run state
   logic [FIELD_BITS-1:0] field_count_ff, field_count_in;
   logic                  field_text_ff, field_text_in;
   logic                  some_blank_ff, some_blank_in;
   logic                  line_text_ff, line_text_in;
   logic                  after_cr_ff, after_cr_in;
   logic [COUNT_BITS-1:0] line_ff, line_in;
   logic [COUNT_BITS-1:0] bad_ff, bad_in;
   logic [COUNT_BITS-1:0] first_line_ff, first_line_in;
   reason_type            first_reason_ff, first_reason_in;

   // result register
   logic                  out_valid_ff;
   logic [COUNT_BITS-1:0] out_line_ff, out_bad_ff, out_first_ff;
   line_status_type       out_status_ff;
   reason_type            out_reason_ff;
   logic                  out_done_ff;

   logic                  accept;
   logic                  is_end, is_lf, is_cr, is_pipe, is_space;
   logic                  close_now;
   logic [COUNT_BITS-1:0] close_line_nr, close_bad, close_first;
   reason_type            close_reason;
   line_status_type       close_status;

   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // byte classification
   assign is_end   = (req_kind == KIND_END);
   assign is_lf    = (req_char_code == CHAR_LF);
   assign is_cr    = (req_char_code == CHAR_CR);
   assign is_pipe  = (req_char_code == CHAR_PIPE);
   assign is_space = (req_char_code == CHAR_SP) || (req_char_code == CHAR_TAB) ||
                     (req_char_code == CHAR_VT) || (req_char_code == CHAR_FF);

   assign close_now = is_end || is_cr || (is_lf && !after_cr_ff);

   // line close evaluation
   always_comb begin
      close_line_nr = (line_ff != COUNT_MAX) ? line_ff + COUNT_BITS'(1) : line_ff;
      if (skip_blank_ff && !line_text_ff) begin
         close_status = STATUS_SKIPPED;
      end else if (CMP_BITS'(field_count_ff) != CMP_BITS'(required_ff)) begin
         close_status = STATUS_MISMATCH;
      end else if (some_blank_ff || !field_text_ff) begin
         close_status = STATUS_EMPTY;
      end else begin
         close_status = STATUS_VALID;
      end
      close_bad    = bad_ff;
      close_first  = first_line_ff;
      close_reason = first_reason_ff;
      if (close_status == STATUS_MISMATCH || close_status == STATUS_EMPTY) begin
         if (bad_ff != COUNT_MAX) begin
            close_bad = bad_ff + COUNT_BITS'(1);
         end
         if (first_line_ff == '0) begin
            close_first  = close_line_nr;
            close_reason = (close_status == STATUS_MISMATCH) ? REASON_MISMATCH
                                                             : REASON_EMPTY;
         end
      end
   end

   // next state for one accepted transfer
   always_comb begin
      field_count_in  = field_count_ff;
      field_text_in   = field_text_ff;
      some_blank_in   = some_blank_ff;
      line_text_in    = line_text_ff;
      after_cr_in     = after_cr_ff;
      line_in         = line_ff;
      bad_in          = bad_ff;
      first_line_in   = first_line_ff;
      first_reason_in = first_reason_ff;
      if (is_end) begin
         field_count_in  = FIELD_BITS'(1);
         field_text_in   = 1'b0;
         some_blank_in   = 1'b0;
         line_text_in    = 1'b0;
         after_cr_in     = 1'b0;
         line_in         = '0;
         bad_in          = '0;
         first_line_in   = '0;
         first_reason_in = REASON_NONE;
      end else if (is_lf && after_cr_ff) begin
         after_cr_in = 1'b0;
      end else if (is_lf || is_cr) begin
         field_count_in  = FIELD_BITS'(1);
         field_text_in   = 1'b0;
         some_blank_in   = 1'b0;
         line_text_in    = 1'b0;
         after_cr_in     = is_cr;
         line_in         = close_line_nr;
         bad_in          = close_bad;
         first_line_in   = close_first;
         first_reason_in = close_reason;
      end else begin
         after_cr_in = 1'b0;
         if (is_pipe) begin
            if (!field_text_ff) begin
               some_blank_in = 1'b1;
            end
            if (field_count_ff != FIELD_MAX) begin
               field_count_in = field_count_ff + FIELD_BITS'(1);
            end
            field_text_in = 1'b0;
            line_text_in  = 1'b1;
         end else if (!is_space) begin
            field_text_in = 1'b1;
            line_text_in  = 1'b1;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         required_ff   <= REQ_BITS'(1);
         skip_blank_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_REQUIRED_FIELDS: required_ff   <= csr_write_data[REQ_BITS-1:0];
            REG_SKIP_BLANK:      skip_blank_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // state update
   always_ff @(posedge clock) begin
      if (reset) begin
         field_count_ff  <= FIELD_BITS'(1);
         field_text_ff   <= 1'b0;
         some_blank_ff   <= 1'b0;
         line_text_ff    <= 1'b0;
         after_cr_ff     <= 1'b0;
         line_ff         <= '0;
         bad_ff          <= '0;
         first_line_ff   <= '0;
         first_reason_ff <= REASON_NONE;
      end else if (accept) begin
         field_count_ff  <= field_count_in;
         field_text_ff   <= field_text_in;
         some_blank_ff   <= some_blank_in;
         line_text_ff    <= line_text_in;
         after_cr_ff     <= after_cr_in;
         line_ff         <= line_in;
         bad_ff          <= bad_in;
         first_line_ff   <= first_line_in;
         first_reason_ff <= first_reason_in;
      end
   end

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= close_now;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept && close_now) begin
         out_line_ff   <= close_line_nr;
         out_status_ff <= close_status;
         out_bad_ff    <= close_bad;
         out_first_ff  <= close_first;
         out_reason_ff <= close_reason;
         out_done_ff   <= is_end;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_line_number        = OUT_BITS'(out_line_ff);
   assign rsp_line_status        = out_status_ff;
   assign rsp_invalid_count      = OUT_BITS'(out_bad_ff);
   assign rsp_first_invalid_line = OUT_BITS'(out_first_ff);
   assign rsp_first_reason       = out_reason_ff;
   assign rsp_all_ok             = (out_bad_ff == '0);
   assign rsp_done_res           = out_done_ff;

endmodule

// ----- design/drlc_checker.sv -----
// ----------------------------------------------------------------------------
// drlc_checker
// Port level checks of the delimited record line checker.
// ----------------------------------------------------------------------------
module drlc_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [drlc_pkg::OUT_BITS-1:0]      rsp_line_number,
   input  logic [1:0]                         rsp_line_status,
   input  logic [drlc_pkg::OUT_BITS-1:0]      rsp_invalid_count,
   input  logic [drlc_pkg::OUT_BITS-1:0]      rsp_first_invalid_line,
   input  logic [1:0]                         rsp_first_reason,
   input  logic                               rsp_all_ok,
   input  logic                               rsp_done_res
);
   import drlc_pkg::*;

   // a pending result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_number) &&
      $stable(rsp_line_status) && $stable(rsp_done_res))
      else $error("pending result changed before transfer");

   // all_ok tracks the invalid count
   a_all_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_all_ok == (rsp_invalid_count == '0)))
      else $error("all_ok disagrees with invalid count");

   // an invalid line leaves a first invalid record behind
   a_first_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_line_status == STATUS_MISMATCH ||
                    rsp_line_status == STATUS_EMPTY)
      |-> !rsp_all_ok && (rsp_first_invalid_line != '0) &&
          (rsp_first_reason != REASON_NONE))
      else $error("invalid line without first invalid record");

   // no input is refused while the result side is free
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // a transfer after end of text starts counting afresh
   a_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_done_res |=>
      !rsp_valid || (rsp_line_number == OUT_BITS'(1)))
      else $error("line numbering not restarted after end of text");

endmodule

bind delimited_record_line_checker drlc_checker u_drlc_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_ready              (req_ready),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_line_number        (rsp_line_number),
   .rsp_line_status        (rsp_line_status),
   .rsp_invalid_count      (rsp_invalid_count),
   .rsp_first_invalid_line (rsp_first_invalid_line),
   .rsp_first_reason       (rsp_first_reason),
   .rsp_all_ok             (rsp_all_ok),
   .rsp_done_res           (rsp_done_res)
);
